// ===== hw/rtl/gemv_with_abft_checksum_defines.svh =====
// assertion macros for the gemv checksum block
`ifndef GEMV_WITH_ABFT_CHECKSUM_DEFINES_SVH
`define GEMV_WITH_ABFT_CHECKSUM_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GAC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("gemv check failed");
// next-cycle implication
`define GAC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("gemv check failed");
`endif

// ===== hw/rtl/gac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gac_pkg
// shared types and constants of the gemv checksum block
// ----------------------------------------------------------------------------
package gac_pkg;
	localparam int MaxRows = 256;
	localparam int MaxCols = 256;
	localparam int FracBits = 13;
	localparam int IdxW = 8;
	localparam int CntW = 9;
	localparam int YW = 32;
	localparam int CsW = 26;
	localparam int WideW = 40;

	localparam logic [2:0] FN_LOAD_Y = 3'd0;
	localparam logic [2:0] FN_LOAD_X = 3'd1;
	localparam logic [2:0] FN_ELEM = 3'd2;
	localparam logic [2:0] FN_READ = 3'd3;
	localparam logic [2:0] FN_CHECK = 3'd4;

	localparam logic [2:0] REG_ROWS = 3'd0;
	localparam logic [2:0] REG_COLS = 3'd1;
	localparam logic [2:0] REG_ALPHA_RE = 3'd2;
	localparam logic [2:0] REG_ALPHA_IM = 3'd3;
	localparam logic [2:0] REG_BETA_RE = 3'd4;
	localparam logic [2:0] REG_BETA_IM = 3'd5;

	// saturate a wide signed value to the y range
	function automatic logic signed [YW-1:0] sat_y(input logic signed [WideW-1:0] v);
		logic signed [WideW-1:0] hi;
		logic signed [WideW-1:0] lo;
		hi = WideW'(signed'({1'b0, {(YW-1){1'b1}}}));
		lo = -hi - WideW'(1);
		if (v > hi) return hi[YW-1:0];
		else if (v < lo) return lo[YW-1:0];
		else return v[YW-1:0];
	endfunction
endpackage

// ===== hw/rtl/gemv_with_abft_checksum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemv_with_abft_checksum
// complex y = alpha*A*x + beta*y with an abft checksum, one word at a time
// ----------------------------------------------------------------------------
// Each word runs through a sequencer that drives one shared real multiplier
// (40 x 26 bits signed). A matrix element runs two chained complex products,
// four real products each; the single multiplier and the one-read-per-cycle
// memories set the pace, so the block takes a new word only after the last
// one is through. s_tready is low while a word is in work and while a result
// waits unaccepted in the output register.
// After reset a clearing pass zeroes every entry of the memories first.
module gemv_with_abft_checksum (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // row[7:0], col[15:8], value_re[31:16], value_im[47:32]
	input  logic [2:0]   s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // data_re, data_im, predicted_re, predicted_im (40 b each)
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);
	localparam int W = gac_pkg::WideW;
	localparam int YW = gac_pkg::YW;
	localparam int CW = gac_pkg::CsW;
	localparam int F = gac_pkg::FracBits;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_MUL, ST_YLOAD, ST_ELEM_WB, ST_SUMY, ST_CSUM,
		ST_CPROD, ST_OUT
	} state_t;

	// configuration
	logic [8:0] rows_q, cols_q;
	logic signed [15:0] alpha_re_q, alpha_im_q, beta_re_q, beta_im_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 9'd1; cols_q <= 9'd1;
			alpha_re_q <= 16'sd8192; alpha_im_q <= '0;
			beta_re_q <= 16'sd8192; beta_im_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gac_pkg::REG_ROWS: rows_q <= cfg_wdata[8:0];
				gac_pkg::REG_COLS: cols_q <= cfg_wdata[8:0];
				gac_pkg::REG_ALPHA_RE: alpha_re_q <= cfg_wdata;
				gac_pkg::REG_ALPHA_IM: alpha_im_q <= cfg_wdata;
				gac_pkg::REG_BETA_RE: beta_re_q <= cfg_wdata;
				gac_pkg::REG_BETA_IM: beta_im_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// counts in use, limited to 1..256
	logic [8:0] rows_use, cols_use;
	assign rows_use = (rows_q == '0) ? 9'd1 : (rows_q > 9'd256 ? 9'd256 : rows_q);
	assign cols_use = (cols_q == '0) ? 9'd1 : (cols_q > 9'd256 ? 9'd256 : cols_q);

	// memories
	logic [63:0] y_mem [gac_pkg::MaxRows];
	logic [31:0] x_mem [gac_pkg::MaxCols];
	logic [51:0] c_mem [gac_pkg::MaxCols];
	logic [7:0]  y_ra, x_ra, c_ra, y_wa, x_wa, c_wa;
	logic        y_we, x_we, c_we;
	logic [63:0] y_wd, y_rd_q;
	logic [31:0] x_wd, x_rd_q;
	logic [51:0] c_wd, c_rd_q;
	always_ff @(posedge clk) begin
		if (y_we) y_mem[y_wa] <= y_wd;
		if (x_we) x_mem[x_wa] <= x_wd;
		if (c_we) c_mem[c_wa] <= c_wd;
		y_rd_q <= y_mem[y_ra];
		x_rd_q <= x_mem[x_ra];
		c_rd_q <= c_mem[c_ra];
	end

	// shared multiplier: a (40 b) times b (26 b)
	logic signed [W-1:0] mul_a;
	logic signed [CW-1:0] mul_b;
	logic signed [W+CW-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	state_t state_q, ret_q;
	logic [2:0] func_q;
	logic [7:0] row_q, col_q;
	logic signed [15:0] v_re_q, v_im_q;
	logic [8:0] cnt_q;
	logic [1:0] ph_q;
	logic signed [W-1:0] ar_q, ai_q;
	logic signed [CW-1:0] br_q, bi_q;
	logic signed [W+CW:0] acc_re_q, acc_im_q;
	logic [1:0] pass_q;
	logic signed [W-1:0] s_re_q, s_im_q, p_re_q, p_im_q, cy_re_q, cy_im_q;
	logic signed [W-1:0] o0_q, o1_q, o2_q, o3_q;
	logic out_v_q;

	// floored product results of the complex multiply in progress
	logic signed [W+CW:0] fre, fim;
	assign fre = acc_re_q >>> F;
	assign fim = acc_im_q >>> F;

	// accumulated imaginary part after the last phase
	logic signed [W+CW:0] last_im;
	assign last_im = acc_im_q + (W+CW+1)'(mul_p);

	// multiplier operand selection by phase: ar*br, ai*bi, ar*bi, ai*br
	always_comb begin
		case (ph_q)
			2'd0: begin mul_a = ar_q; mul_b = br_q; end
			2'd1: begin mul_a = ai_q; mul_b = bi_q; end
			2'd2: begin mul_a = ar_q; mul_b = bi_q; end
			default: begin mul_a = ai_q; mul_b = br_q; end
		endcase
	end

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !(out_v_q && !m_tready);

	logic signed [YW-1:0] y_re_cur, y_im_cur;
	assign y_re_cur = y_rd_q[63:32];
	assign y_im_cur = y_rd_q[31:0];

	// memory ports
	always_comb begin
		y_we = 1'b0; x_we = 1'b0; c_we = 1'b0;
		y_wa = row_q; x_wa = col_q; c_wa = col_q;
		y_wd = '0; x_wd = '0; c_wd = '0;
		y_ra = row_q; x_ra = col_q; c_ra = col_q;
		if (state_q == ST_IDLE && in_acc) begin
			y_ra = s_tdata[7:0]; x_ra = s_tdata[15:8]; c_ra = s_tdata[15:8];
		end
		if (state_q == ST_SUMY || state_q == ST_CSUM || state_q == ST_CPROD) begin
			y_ra = cnt_q[7:0]; x_ra = cnt_q[7:0]; c_ra = cnt_q[7:0];
		end
		case (state_q)
			ST_CLEAR: begin
				y_we = 1'b1; x_we = 1'b1; c_we = 1'b1;
				y_wa = cnt_q[7:0]; x_wa = cnt_q[7:0]; c_wa = cnt_q[7:0];
			end
			ST_RD: if (func_q == gac_pkg::FN_LOAD_X && {1'b0, col_q} < cols_use) begin
				x_we = 1'b1; x_wd = {v_re_q, v_im_q};
				c_we = 1'b1; c_wd = '0;
			end
			ST_YLOAD: begin
				y_we = 1'b1;
				y_wd = {gac_pkg::sat_y(W'(fre)), gac_pkg::sat_y(W'(fim))};
			end
			// write back only after the second product
			ST_ELEM_WB: if (pass_q == 2'd1) begin
				y_we = 1'b1;
				y_wd = {gac_pkg::sat_y(W'(y_re_cur) + W'(fre)),
					gac_pkg::sat_y(W'(y_im_cur) + W'(fim))};
				c_we = 1'b1;
				c_wd = {CW'(c_rd_q[51:26] + CW'(v_re_q)), CW'(c_rd_q[25:0] + CW'(v_im_q))};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; ret_q <= ST_IDLE; cnt_q <= '0; ph_q <= '0; pass_q <= '0;
			out_v_q <= 1'b0; cy_re_q <= '0; cy_im_q <= '0;
		end else begin
			// output register valid
			if (state_q == ST_OUT && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd255) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_acc) begin
					func_q <= s_tuser; row_q <= s_tdata[7:0]; col_q <= s_tdata[15:8];
					v_re_q <= s_tdata[31:16]; v_im_q <= s_tdata[47:32];
					state_q <= ST_RD;
				end
				ST_RD: begin
					ph_q <= '0; acc_re_q <= '0; acc_im_q <= '0; pass_q <= '0;
					case (func_q)
						gac_pkg::FN_LOAD_Y: if ({1'b0, row_q} < rows_use) begin
							ar_q <= W'(beta_re_q); ai_q <= W'(beta_im_q);
							br_q <= CW'(v_re_q); bi_q <= CW'(v_im_q);
							ret_q <= ST_YLOAD; state_q <= ST_MUL;
						end else state_q <= ST_IDLE;
						gac_pkg::FN_ELEM:
							if ({1'b0, row_q} < rows_use && {1'b0, col_q} < cols_use) begin
							ar_q <= W'(alpha_re_q); ai_q <= W'(alpha_im_q);
							br_q <= CW'($signed(x_rd_q[31:16]));
							bi_q <= CW'($signed(x_rd_q[15:0]));
							ret_q <= ST_ELEM_WB; state_q <= ST_MUL;
						end else state_q <= ST_IDLE;
						gac_pkg::FN_READ: begin
							if ({1'b0, row_q} < rows_use) begin
								o0_q <= W'(y_re_cur); o1_q <= W'(y_im_cur);
							end else begin
								o0_q <= '0; o1_q <= '0;
							end
							o2_q <= '0; o3_q <= '0;
							state_q <= ST_OUT;
						end
						gac_pkg::FN_CHECK: begin
							s_re_q <= '0; s_im_q <= '0; p_re_q <= cy_re_q; p_im_q <= cy_im_q;
							cnt_q <= '0; state_q <= ST_SUMY;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_MUL: begin
					ph_q <= ph_q + 2'd1;
					case (ph_q)
						2'd0: acc_re_q <= (W+CW+1)'(mul_p);
						2'd1: acc_re_q <= acc_re_q - (W+CW+1)'(mul_p);
						2'd2: acc_im_q <= (W+CW+1)'(mul_p);
						default: begin
							acc_im_q <= last_im;
							state_q <= ret_q;
						end
					endcase
				end
				ST_YLOAD: begin
					if (row_q == '0) begin
						cy_re_q <= W'(gac_pkg::sat_y(W'(fre)));
						cy_im_q <= W'(gac_pkg::sat_y(W'(fim)));
					end else begin
						cy_re_q <= cy_re_q + W'(gac_pkg::sat_y(W'(fre)));
						cy_im_q <= cy_im_q + W'(gac_pkg::sat_y(W'(fim)));
					end
					state_q <= ST_IDLE;
				end
				ST_ELEM_WB: begin
					if (pass_q == 2'd0) begin
						// second product: (alpha*x) * A
						ar_q <= W'(fre); ai_q <= W'(fim);
						br_q <= CW'(v_re_q); bi_q <= CW'(v_im_q);
						acc_re_q <= '0; acc_im_q <= '0; ph_q <= '0;
						pass_q <= 2'd1; state_q <= ST_MUL;
					end else state_q <= ST_IDLE;
				end
				// sum y over the rows; read data arrives the cycle after its address
				ST_SUMY: begin
					if (cnt_q != '0) begin
						s_re_q <= s_re_q + W'(y_re_cur);
						s_im_q <= s_im_q + W'(y_im_cur);
					end
					if (cnt_q == rows_use) begin
						cnt_q <= '0; state_q <= ST_CSUM;
					end else cnt_q <= cnt_q + 9'd1;
				end
				// column step: fetch c and x, first product c*x
				ST_CSUM: begin
					if (pass_q == 2'd0) pass_q <= 2'd1;
					else begin
						ar_q <= W'($signed(c_rd_q[51:26])); ai_q <= W'($signed(c_rd_q[25:0]));
						br_q <= CW'($signed(x_rd_q[31:16])); bi_q <= CW'($signed(x_rd_q[15:0]));
						acc_re_q <= '0; acc_im_q <= '0; ph_q <= '0;
						pass_q <= 2'd2; ret_q <= ST_CPROD; state_q <= ST_MUL;
					end
				end
				ST_CPROD: begin
					if (pass_q == 2'd2) begin
						ar_q <= W'(fre); ai_q <= W'(fim);
						br_q <= CW'(alpha_re_q); bi_q <= CW'(alpha_im_q);
						acc_re_q <= '0; acc_im_q <= '0; ph_q <= '0;
						pass_q <= 2'd3; state_q <= ST_MUL;
					end else begin
						p_re_q <= p_re_q + W'(fre);
						p_im_q <= p_im_q + W'(fim);
						pass_q <= '0;
						if (cnt_q + 9'd1 == cols_use) begin
							o0_q <= s_re_q; o1_q <= s_im_q;
							o2_q <= p_re_q + W'(fre); o3_q <= p_im_q + W'(fim);
							state_q <= ST_OUT;
						end else begin
							cnt_q <= cnt_q + 9'd1; state_q <= ST_CSUM;
						end
					end
				end
				ST_OUT: if (!out_v_q || m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {o3_q, o2_q, o1_q, o0_q};
endmodule

// ===== hw/rtl/gac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gac_checker
// port-level checks of the gemv checksum block
// ----------------------------------------------------------------------------
`include "gemv_with_abft_checksum_defines.svh"
module gac_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata
);
	// a word taken closes the input in the next cycle
	`GAC_ASSERT_NXT(a_busy_after_word, s_tvalid && s_tready, !s_tready)
	// a stalled result holds
	`GAC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// no new word while a result is stalled
	`GAC_ASSERT_IMP(a_no_new_word_while_full, m_tvalid && !m_tready, !s_tready)
endmodule

bind gemv_with_abft_checksum gac_checker u_gac_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams y loads, x loads, matrix elements, reads and checksum checks into
// the gemv checksum block and compares each returned word with a predictor
// ----------------------------------------------------------------------------

// predicts the gemv state and keeps the words still owed by the block
class gemv_scoreboard;
	typedef struct {
		logic [gac_pkg::WideW-1:0] d_re;
		logic [gac_pkg::WideW-1:0] d_im;
		logic [gac_pkg::WideW-1:0] p_re;
		logic [gac_pkg::WideW-1:0] p_im;
	} gemv_word_t;

	longint y_re[gac_pkg::MaxRows], y_im[gac_pkg::MaxRows];
	longint x_re[gac_pkg::MaxCols], x_im[gac_pkg::MaxCols];
	longint c_re[gac_pkg::MaxCols], c_im[gac_pkg::MaxCols];
	longint cy_re, cy_im;
	longint a_re, a_im, b_re, b_im;
	logic [gac_pkg::CntW-1:0] rows_raw, cols_raw;
	gemv_word_t owed[$];
	int errors;
	int reads_seen, checks_seen;

	function new();
		foreach (y_re[i]) begin
			y_re[i] = 0;
			y_im[i] = 0;
		end
		foreach (x_re[i]) begin
			x_re[i] = 0;
			x_im[i] = 0;
			c_re[i] = 0;
			c_im[i] = 0;
		end
		cy_re = 0;
		cy_im = 0;
		rows_raw = 1;
		cols_raw = 1;
		a_re = 8192;
		a_im = 0;
		b_re = 8192;
		b_im = 0;
		errors = 0;
		reads_seen = 0;
		checks_seen = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] d);
		case (idx)
			gac_pkg::REG_ROWS: rows_raw = d[gac_pkg::CntW-1:0];
			gac_pkg::REG_COLS: cols_raw = d[gac_pkg::CntW-1:0];
			gac_pkg::REG_ALPHA_RE: a_re = longint'($signed(d));
			gac_pkg::REG_ALPHA_IM: a_im = longint'($signed(d));
			gac_pkg::REG_BETA_RE: b_re = longint'($signed(d));
			gac_pkg::REG_BETA_IM: b_im = longint'($signed(d));
			default: ;
		endcase
	endfunction

	function int rows_in_use();
		if (rows_raw == 0) return 1;
		if (rows_raw > gac_pkg::MaxRows) return gac_pkg::MaxRows;
		return int'(rows_raw);
	endfunction

	function int cols_in_use();
		if (cols_raw == 0) return 1;
		if (cols_raw > gac_pkg::MaxCols) return gac_pkg::MaxCols;
		return int'(cols_raw);
	endfunction

	// two's complement wrap to w bits
	function longint wrap(longint v, int w);
		return (v <<< (64 - w)) >>> (64 - w);
	endfunction

	function longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// complex product, truncated toward minus infinity
	function void cmul(input longint ar, ai, br, bi, output longint rr, ri);
		rr = (ar * br - ai * bi) >>> gac_pkg::FracBits;
		ri = (ar * bi + ai * br) >>> gac_pkg::FracBits;
	endfunction

	function void note_word(logic [2:0] fn, logic [7:0] row, logic [7:0] col,
			logic signed [15:0] vr, logic signed [15:0] vi);
		longint pr, pi, tr, ti, sr, si, qr, qi;
		int m, n;
		gemv_word_t w;
		m = rows_in_use();
		n = cols_in_use();
		case (fn)
			gac_pkg::FN_LOAD_Y: if (row < m) begin
				cmul(b_re, b_im, vr, vi, pr, pi);
				y_re[row] = sat32(pr);
				y_im[row] = sat32(pi);
				if (row == 0) begin
					cy_re = 0;
					cy_im = 0;
				end
				cy_re = wrap(cy_re + y_re[row], gac_pkg::WideW);
				cy_im = wrap(cy_im + y_im[row], gac_pkg::WideW);
			end
			gac_pkg::FN_LOAD_X: if (col < n) begin
				x_re[col] = vr;
				x_im[col] = vi;
				c_re[col] = 0;
				c_im[col] = 0;
			end
			gac_pkg::FN_ELEM: if (row < m && col < n) begin
				cmul(a_re, a_im, x_re[col], x_im[col], tr, ti);
				cmul(tr, ti, vr, vi, pr, pi);
				y_re[row] = sat32(y_re[row] + pr);
				y_im[row] = sat32(y_im[row] + pi);
				c_re[col] = wrap(c_re[col] + vr, gac_pkg::CsW);
				c_im[col] = wrap(c_im[col] + vi, gac_pkg::CsW);
			end
			gac_pkg::FN_READ: begin
				// a row beyond the count reads as zero
				w.d_re = (row < m) ? y_re[row][gac_pkg::WideW-1:0] : '0;
				w.d_im = (row < m) ? y_im[row][gac_pkg::WideW-1:0] : '0;
				w.p_re = '0;
				w.p_im = '0;
				owed.push_back(w);
				reads_seen++;
			end
			gac_pkg::FN_CHECK: begin
				sr = 0;
				si = 0;
				for (int i = 0; i < m; i++) begin
					sr = wrap(sr + y_re[i], gac_pkg::WideW);
					si = wrap(si + y_im[i], gac_pkg::WideW);
				end
				qr = cy_re;
				qi = cy_im;
				for (int i = 0; i < n; i++) begin
					cmul(c_re[i], c_im[i], x_re[i], x_im[i], tr, ti);
					cmul(tr, ti, a_re, a_im, pr, pi);
					qr = wrap(qr + pr, gac_pkg::WideW);
					qi = wrap(qi + pi, gac_pkg::WideW);
				end
				w.d_re = sr[gac_pkg::WideW-1:0];
				w.d_im = si[gac_pkg::WideW-1:0];
				w.p_re = qr[gac_pkg::WideW-1:0];
				w.p_im = qi[gac_pkg::WideW-1:0];
				owed.push_back(w);
				checks_seen++;
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [159:0] t);
		gemv_word_t w;
		if (owed.size() == 0) begin
			$display("%0t: unexpected word, expected none, got %h", $time, t);
			errors++;
			return;
		end
		w = owed.pop_front();
		if (t[39:0] !== w.d_re) begin
			$display("%0t: data_re expected %h got %h", $time, w.d_re, t[39:0]);
			errors++;
		end
		if (t[79:40] !== w.d_im) begin
			$display("%0t: data_im expected %h got %h", $time, w.d_im, t[79:40]);
			errors++;
		end
		if (t[119:80] !== w.p_re) begin
			$display("%0t: predicted_re expected %h got %h", $time, w.p_re, t[119:80]);
			errors++;
		end
		if (t[159:120] !== w.p_im) begin
			$display("%0t: predicted_im expected %h got %h", $time, w.p_im, t[159:120]);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int IdleLimit = 50000;
	localparam int LongHold = 400;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_wdata;

	gemv_scoreboard sb;
	int burst_left;
	int words_sent;
	int idle_cycles;
	int rx_cycle;
	int hold_left;
	bit hold_req;

	gemv_with_abft_checksum DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver: checks words and stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			rx_cycle++;
			if (hold_req) begin
				hold_req = 0;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 97) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no progress for %0d cycles", $time, IdleLimit);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one word, in bursts with random gaps
	task automatic send_word(logic [2:0] fn, logic [7:0] row, logic [7:0] col,
			logic [15:0] vr, logic [15:0] vi);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {vi, vr, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(fn, row, col, vr, vi);
		burst_left--;
		words_sent++;
	endtask

	// wait for every owed word, then for the block to settle
	task automatic drain();
		int quiet;
		quiet = 0;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.owed.size() != 0) @(posedge clk);
		while (quiet < 30) begin
			@(posedge clk);
			quiet = s_tready ? quiet + 1 : 0;
		end
	endtask

	task automatic set_regs(logic [15:0] rows, logic [15:0] cols, logic [15:0] ar,
			logic [15:0] ai, logic [15:0] br, logic [15:0] bi);
		logic [15:0] vals[6];
		vals = '{rows, cols, ar, ai, br, bi};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(3'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// a random word that the block may ignore
	task automatic send_noise();
		send_word(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// one pass: y, x, elements, reads, check, a last read; noise words mixed in
	task automatic run_pass(bit with_hold);
		int m, n, k;
		m = sb.rows_in_use();
		n = sb.cols_in_use();
		for (int r = 0; r < m && r < 20; r++) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			send_word(gac_pkg::FN_LOAD_Y, 8'(r), 8'($urandom), rand_value(), rand_value());
		end
		if (m > 20)
			send_word(gac_pkg::FN_LOAD_Y, 8'(m - 1), 8'($urandom), rand_value(),
				rand_value());
		for (int c = 0; c < n && c < 20; c++) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			send_word(gac_pkg::FN_LOAD_X, 8'($urandom), 8'(c), rand_value(), rand_value());
		end
		if (n > 20)
			send_word(gac_pkg::FN_LOAD_X, 8'($urandom), 8'(n - 1), rand_value(),
				rand_value());
		k = $urandom_range(10, 40);
		repeat (k) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			send_word(gac_pkg::FN_ELEM, 8'($urandom_range(0, m - 1)),
				8'($urandom_range(0, n - 1)), rand_value(), rand_value());
		end
		// receiver holds off while reads pile up behind the output register
		if (with_hold) hold_req = 1;
		repeat (with_hold ? 8 : 4)
			send_word(gac_pkg::FN_READ, 8'($urandom_range(0, m - 1)), 8'($urandom),
				16'($urandom), 16'($urandom));
		send_word(gac_pkg::FN_CHECK, 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom));
		send_word(gac_pkg::FN_READ, 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom));
		drain();
	endtask

	initial begin
		int pass_no;
		sb = new();
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		burst_left = 0;
		words_sent = 0;
		idle_cycles = 0;
		hold_req = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings first, then extreme alpha and beta
		send_word(gac_pkg::FN_LOAD_Y, 8'd0, 8'd0, 16'h7fff, 16'h8000);
		send_word(gac_pkg::FN_READ, 8'd0, 8'd0, 16'h0, 16'h0);
		send_word(gac_pkg::FN_CHECK, 8'd0, 8'd0, 16'h0, 16'h0);
		drain();
		set_regs(16'd4, 16'd4, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_word(gac_pkg::FN_LOAD_Y, 8'd0, 8'd0, 16'h8000, 16'h8000);
		send_word(gac_pkg::FN_LOAD_Y, 8'd3, 8'd0, 16'h7fff, 16'h7fff);
		send_word(gac_pkg::FN_LOAD_Y, 8'd9, 8'd0, 16'h7fff, 16'h7fff);
		send_word(gac_pkg::FN_LOAD_X, 8'd0, 8'd0, 16'h8000, 16'h7fff);
		send_word(gac_pkg::FN_LOAD_X, 8'd0, 8'd3, 16'h7fff, 16'h8000);
		send_word(gac_pkg::FN_LOAD_X, 8'd0, 8'hff, 16'h7fff, 16'h8000);
		send_word(gac_pkg::FN_ELEM, 8'd0, 8'd0, 16'h8000, 16'h8000);
		send_word(gac_pkg::FN_ELEM, 8'd3, 8'd3, 16'h7fff, 16'h8000);
		send_word(gac_pkg::FN_ELEM, 8'd3, 8'd7, 16'h7fff, 16'h7fff);
		send_word(gac_pkg::FN_ELEM, 8'hff, 8'd0, 16'h7fff, 16'h7fff);
		send_word(3'd5, 8'hff, 8'hff, 16'hffff, 16'hffff);
		send_word(3'd6, 8'd1, 8'd1, 16'h1, 16'h1);
		send_word(3'd7, 8'd2, 8'd2, 16'h2, 16'h2);
		send_word(gac_pkg::FN_READ, 8'd0, 8'd0, 16'h0, 16'h0);
		send_word(gac_pkg::FN_READ, 8'd3, 8'd0, 16'h0, 16'h0);
		send_word(gac_pkg::FN_READ, 8'hff, 8'd0, 16'h0, 16'h0);
		send_word(gac_pkg::FN_CHECK, 8'd0, 8'd0, 16'h0, 16'h0);
		drain();

		// random passes through many settings, extremes among them
		pass_no = 0;
		while (words_sent < 1400) begin
			case (pass_no)
				0: set_regs(16'd0, 16'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
				1: set_regs(16'd256, 16'd256, rand_value(), rand_value(),
					rand_value(), rand_value());
				2: set_regs(16'd511, 16'd300, rand_value(), rand_value(),
					rand_value(), rand_value());
				default: set_regs(16'($urandom_range(1, 24)), 16'($urandom_range(1, 24)),
					rand_value(), rand_value(), rand_value(), rand_value());
			endcase
			run_pass(pass_no == 4);
			pass_no++;
		end

		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d words in %0d configuration passes: %0d reads, %0d checks",
			words_sent, pass_no + 2, sb.reads_seen, sb.checks_seen);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
